// File: sv/assert_macros.svh
// assertion macros for the rtl files of the flash block write-back buffer, used by the top file
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FBWB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fbwb assertion failed");

// condition must never be seen outside reset
`define FBWB_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("fbwb forbidden condition seen");

`endif

// File: sv/fbwb_pkg.sv
// package for the flash block write-back buffer
// holds transaction structs, action codes and default sizes; no dependencies
package fbwb_pkg;

  localparam int FBWB_BLOCK_BYTES = 64;
  localparam int FBWB_FLASH_BYTES = 65536;
  localparam int FBWB_QUEUE_DEPTH = 2;
  localparam logic [7:0] FBWB_ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ACT_READ        = 2'd0,
    ACT_WRITE       = 2'd1,
    ACT_WRITE_FLUSH = 2'd2,
    ACT_FLUSH       = 2'd3
  } fbwb_action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } fbwb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       erased;
    logic       programmed;
  } fbwb_out_t;

  // decoded command handed from the front end to the back end
  typedef struct packed {
    logic        is_write;
    logic        flush_after;
    logic        flush_only;
    logic [15:0] address;
    logic [7:0]  write_data;
  } fbwb_cmd_t;

endpackage

// File: sv/fbwb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module fbwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fbwb_front.sv
// front end: takes input transactions and decodes the action into a command
// depends on fbwb_pkg
module fbwb_front import fbwb_pkg::*; (
  input  fbwb_in_t  in_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      q_full_i,
  input  logic      busy_i,
  output logic      push_o,
  output fbwb_cmd_t cmd_o
);

  // hold off while the queue is full or the array is being cleared
  assign in_stall_o = q_full_i || busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.address     = in_i.address;
    cmd_o.write_data  = in_i.write_data;
    unique case (fbwb_action_e'(in_i.action))
      ACT_READ: begin
      end
      ACT_WRITE: begin
        cmd_o.is_write = 1'b1;
      end
      ACT_WRITE_FLUSH: begin
        cmd_o.is_write    = 1'b1;
        cmd_o.flush_after = 1'b1;
      end
      ACT_FLUSH: begin
        cmd_o.flush_only = 1'b1;
      end
    endcase
  end

endmodule

// File: sv/fbwb_fifo.sv
// short command queue between front end and back end
// depends on fbwb_pkg
module fbwb_fifo import fbwb_pkg::*; #(
  parameter int DEPTH = FBWB_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fbwb_cmd_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output fbwb_cmd_t data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fbwb_cmd_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: sv/fbwb_back.sv
// back end: block image and flash array, sequencer for load, write-back and access
// depends on fbwb_pkg and fbwb_ram
module fbwb_back import fbwb_pkg::*; #(
  parameter int BLOCK_BYTES = FBWB_BLOCK_BYTES,
  parameter int FLASH_BYTES = FBWB_FLASH_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  fbwb_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      busy_o,
  output fbwb_out_t out_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int FA_W  = $clog2(FLASH_BYTES);
  localparam int TAG_W = FA_W - OFF_W;
  localparam int CNT_W = OFF_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ACCESS,
    ST_WB,
    ST_LOAD,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [FA_W-1:0]  clr_q;
  fbwb_cmd_t        cur_q;
  logic [TAG_W-1:0] tag_q;
  logic             loaded_q;
  logic             modified_q;
  logic             erase_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pend_q;
  logic [OFF_W-1:0] widx_q;
  logic             wb_done_q;
  logic             erased_q;
  logic             prog_q;
  logic [7:0]       rd_q;
  fbwb_out_t        out_q;
  logic             out_valid_q;

  logic [TAG_W-1:0] cur_tag;
  logic [OFF_W-1:0] cur_off;
  logic             hit;
  logic             new_mod;
  logic             new_erase;

  logic             img_we;
  logic [OFF_W-1:0] img_waddr;
  logic [7:0]       img_wdata;
  logic [OFF_W-1:0] img_raddr;
  logic [7:0]       img_rdata;
  logic             fl_we;
  logic [FA_W-1:0]  fl_waddr;
  logic [7:0]       fl_wdata;
  logic [FA_W-1:0]  fl_raddr;
  logic [7:0]       fl_rdata;

  assign cur_tag   = cur_q.address[FA_W-1:OFF_W];
  assign cur_off   = cur_q.address[OFF_W-1:0];
  assign hit       = loaded_q && (tag_q == cur_tag);
  assign new_mod   = modified_q || (cur_q.write_data != img_rdata);
  assign new_erase = erase_q || (|(cur_q.write_data & ~img_rdata));

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign busy_o      = (state_q == ST_CLEAR);
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  // image port: filled during load and by writes, read out during write-back and for accesses
  assign img_we    = ((state_q == ST_LOAD) && pend_q) ||
                     ((state_q == ST_ACCESS) && cur_q.is_write);
  assign img_waddr = (state_q == ST_LOAD) ? widx_q : cur_off;
  assign img_wdata = (state_q == ST_LOAD) ? fl_rdata : cur_q.write_data;
  assign img_raddr = (state_q == ST_WB) ? cnt_q[OFF_W-1:0] : cur_off;

  // flash port: cleared after reset, read during load, programmed during write-back
  assign fl_we    = (state_q == ST_CLEAR) || ((state_q == ST_WB) && pend_q);
  assign fl_waddr = (state_q == ST_CLEAR) ? clr_q : {tag_q, widx_q};
  assign fl_wdata = (state_q == ST_CLEAR) ? FBWB_ERASED_BYTE : img_rdata;
  assign fl_raddr = {cur_tag, cnt_q[OFF_W-1:0]};

  fbwb_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_image (
    .clk_i  (clk_i),
    .we_i   (img_we),
    .waddr_i(img_waddr),
    .wdata_i(img_wdata),
    .raddr_i(img_raddr),
    .rdata_o(img_rdata)
  );

  fbwb_ram #(
    .WIDTH(8),
    .DEPTH(FLASH_BYTES)
  ) u_flash (
    .clk_i  (clk_i),
    .we_i   (fl_we),
    .waddr_i(fl_waddr),
    .wdata_i(fl_wdata),
    .raddr_i(fl_raddr),
    .rdata_o(fl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      tag_q       <= '0;
      loaded_q    <= 1'b0;
      modified_q  <= 1'b0;
      erase_q     <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      widx_q      <= '0;
      wb_done_q   <= 1'b0;
      erased_q    <= 1'b0;
      prog_q      <= 1'b0;
      rd_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the done state handles the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == FA_W'(FLASH_BYTES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cur_q     <= cmd_i;
            erased_q  <= 1'b0;
            prog_q    <= 1'b0;
            rd_q      <= '0;
            wb_done_q <= 1'b0;
            state_q   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
          if (cur_q.flush_only) begin
            wb_done_q <= 1'b1;
            state_q   <= (loaded_q && modified_q) ? ST_WB : ST_DONE;
          end else if (hit) begin
            state_q <= ST_ACCESS;
          end else if (loaded_q && modified_q) begin
            state_q <= ST_WB;
          end else begin
            state_q <= ST_LOAD;
          end
        end
        ST_ACCESS: begin
          if (cur_q.is_write) begin
            modified_q <= new_mod;
            erase_q    <= new_erase;
            if (cur_q.flush_after && new_mod) begin
              wb_done_q <= 1'b1;
              cnt_q     <= '0;
              pend_q    <= 1'b0;
              state_q   <= ST_WB;
            end else begin
              state_q <= ST_DONE;
            end
          end else begin
            rd_q    <= img_rdata;
            state_q <= ST_DONE;
          end
        end
        ST_WB: begin
          if (cnt_q[OFF_W]) begin
            pend_q     <= 1'b0;
            prog_q     <= 1'b1;
            erased_q   <= erased_q || erase_q;
            modified_q <= 1'b0;
            erase_q    <= 1'b0;
            cnt_q      <= '0;
            state_q    <= wb_done_q ? ST_DONE : ST_LOAD;
          end else begin
            cnt_q  <= cnt_q + 1'b1;
            pend_q <= 1'b1;
            widx_q <= cnt_q[OFF_W-1:0];
          end
        end
        ST_LOAD: begin
          if (cnt_q[OFF_W]) begin
            pend_q     <= 1'b0;
            tag_q      <= cur_tag;
            loaded_q   <= 1'b1;
            modified_q <= 1'b0;
            erase_q    <= 1'b0;
            cnt_q      <= '0;
            state_q    <= ST_CHECK;
          end else begin
            cnt_q  <= cnt_q + 1'b1;
            pend_q <= 1'b1;
            widx_q <= cnt_q[OFF_W-1:0];
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.read_data  <= rd_q;
            out_q.erased     <= erased_q;
            out_q.programmed <= prog_q;
            out_valid_q      <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: sv/flash_block_writeback_buffer_top.sv
// Flash block write-back buffer. Byte reads and writes reach a flash array
// (FLASH_BYTES bytes, held in an on-chip ram) through a single image of one
// BLOCK_BYTES-byte block. Each input transaction carries an action (read,
// write into the image, write then flush, flush), a byte address and write
// data, and produces exactly one result transaction with the read byte and
// two flags telling whether a block erase and a block program happened while
// it ran. After reset the array is swept to all ones, one byte per cycle;
// input stall is held high during that pass. A read or write that hits the
// loaded block passes through the back-end sequencer's check, registered
// image read and result register. Loading a new block and writing a
// modified block back each move one byte per cycle through the single port
// pair of each ram. A two-entry queue between the decoding front end and the
// sequencer lets the input side keep taking transactions while a result
// waits on output stall.
//
// depends on fbwb_pkg, fbwb_front, fbwb_fifo, fbwb_back, fbwb_ram
// and assert_macros.svh
`include "assert_macros.svh"

module flash_block_writeback_buffer_top import fbwb_pkg::*; #(
  parameter int BLOCK_BYTES = FBWB_BLOCK_BYTES,
  parameter int FLASH_BYTES = FBWB_FLASH_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fbwb_in_t  in_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output fbwb_out_t out_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  // queue signals between the front end and the sequencer
  logic      push;
  fbwb_cmd_t push_cmd;
  logic      q_full;
  logic      q_empty;
  logic      pop;
  fbwb_cmd_t pop_cmd;
  // high while the array clearing pass runs
  logic      clr_busy;

  // decode the action, hold off on full queue or clearing pass
  fbwb_front u_front (
    .in_i      (in_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .busy_i    (clr_busy),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // decouples input acceptance from the long load and write-back sweeps
  fbwb_fifo #(
    .DEPTH(FBWB_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .data_o (pop_cmd)
  );

  // image, array and the sequencer that runs each transaction
  fbwb_back #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .FLASH_BYTES(FLASH_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (pop),
    .busy_o     (clr_busy),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  // the queue never takes a transaction it has no room for
  `FBWB_ASSERT_NEVER(a_no_queue_overflow, push && q_full && !pop)
  // nothing enters while the array is still being cleared
  `FBWB_ASSERT_NEVER(a_no_accept_in_clear, in_valid_i && !in_stall_o && clr_busy)
  // an erase is always followed by programming within the same transaction
  `FBWB_ASSERT(a_erase_implies_program, !out_valid_o || !out_o.erased || out_o.programmed)
  // the sequencer never pops an empty queue
  `FBWB_ASSERT_NEVER(a_no_pop_empty, pop && q_empty)

endmodule
